[rtl/core/aes_pkg.sv]
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int BlockW    = 128;
   localparam int HalfW     = 64;
   localparam int CsrIdxW   = 1;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   typedef logic [BlockW-1:0] block_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam sbox_table_type INV_SBOX = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   typedef logic [7:0] rcon_table_type [NumRounds];
   localparam rcon_table_type RCON = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   // byte i of the block sits in bits [127-8i -: 8]
   function automatic logic [7:0] get_byte(block_type b, int i);
      return b[BlockW-1-8*i -: 8];
   endfunction

   function automatic logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic block_type sub_shift(block_type s, logic inv);
      block_type t;
      int c, r, src;
      t = '0;
      for (c = 0; c < 4; c++) begin
         for (r = 0; r < 4; r++) begin
            if (inv) begin
               src = ((c + 3 * r) & 3) * 4 + r;
               t[BlockW-1-8*(c*4+r) -: 8] = INV_SBOX[get_byte(s, src)];
            end else begin
               src = ((c + r) & 3) * 4 + r;
               t[BlockW-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, src)];
            end
         end
      end
      return t;
   endfunction

   function automatic block_type mix_fwd(block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      int c;
      t = '0;
      for (c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         t[BlockW-1-8*(c*4)   -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[BlockW-1-8*(c*4+1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[BlockW-1-8*(c*4+2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[BlockW-1-8*(c*4+3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      return t;
   endfunction

   // InvMixColumns as a pre-multiply by {04,00,05,00} then forward mix
   function automatic block_type mix_inv(block_type s);
      block_type u;
      logic [7:0] a0, a1, a2, a3, x, y;
      int c;
      u = '0;
      for (c = 0; c < 4; c++) begin
         a0 = get_byte(s, c*4);
         a1 = get_byte(s, c*4+1);
         a2 = get_byte(s, c*4+2);
         a3 = get_byte(s, c*4+3);
         x = xtime(xtime(a0 ^ a2));
         y = xtime(xtime(a1 ^ a3));
         u[BlockW-1-8*(c*4)   -: 8] = a0 ^ x;
         u[BlockW-1-8*(c*4+1) -: 8] = a1 ^ y;
         u[BlockW-1-8*(c*4+2) -: 8] = a2 ^ x;
         u[BlockW-1-8*(c*4+3) -: 8] = a3 ^ y;
      end
      return mix_fwd(u);
   endfunction

   function automatic block_type next_round_key(block_type k, logic [7:0] rc);
      block_type n;
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n[127:96] = w0 ^ t;
      n[95:64]  = w0 ^ t ^ w1;
      n[63:32]  = w0 ^ t ^ w1 ^ w2;
      n[31:0]   = w0 ^ t ^ w1 ^ w2 ^ w3;
      return n;
   endfunction

endpackage

[rtl/core/aes_word_if.sv]
interface aes_word_if;
   import aes_pkg::*;

   logic      valid;
   logic      ready;
   op_type    op;
   logic [HalfW-1:0] block_high;
   logic [HalfW-1:0] block_low;
   logic [HalfW-1:0] result_high;
   logic [HalfW-1:0] result_low;

   modport source (output valid, op, block_high, block_low, result_high, result_low,
                   input ready);
   modport sink   (input valid, op, block_high, block_low, result_high, result_low,
                   output ready);
endinterface

[rtl/core/aes128_block_cipher_core.sv]
// Throughput: one word per cycle while the key is settled and the output is free or taken;
//   11 register stages (initial key add plus ten rounds) and an output register move together.
// Round keys are expanded one round per register; the request side is held off after a
//   key write or reset until the expansion has settled through every round-key register.
// Reset (synchronous, active high) clears the key and all valid bits and restarts the settle count.
module aes128_block_cipher_core (
   input  logic                       clock,
   input  logic                       reset,
   aes_word_if.sink                   req,
   aes_word_if.source                 rsp,
   input  logic                       csr_we,
   input  aes_pkg::csr_index_type     csr_index,
   input  logic [aes_pkg::HalfW-1:0]  csr_wdata
);
   import aes_pkg::*;

   localparam int NumStages = NumRounds + 2;

   // key registers and round keys; rk_ff[0] is the cipher key
   logic [HalfW-1:0] key_high_ff, key_low_ff;
   block_type        rk_ff [NumRounds+1];
   block_type        rk_in [NumRounds+1];

   // cycles left until rk_ff[NumRounds] holds the current key's schedule
   logic [3:0]       key_wait_ff, key_wait_in;
   logic             key_ready;

   // pipeline: stage 0 is the initial AddRoundKey, 1..10 rounds, 11 output
   block_type        st_ff [NumStages];
   block_type        st_in [NumStages];
   logic             op_ff [NumStages];
   logic             vld_ff [NumStages];
   logic             advance;

   // whole pipe moves in lockstep; stall only when the output word is held
   assign advance   = !vld_ff[NumStages-1] || rsp.ready;
   assign key_ready = (key_wait_ff == 4'd0);
   assign req.ready = advance && key_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // restart the settle count on every key write
   always_comb begin
      if (csr_we) begin
         key_wait_in = 4'(NumRounds + 1);
      end else if (key_wait_ff != 4'd0) begin
         key_wait_in = key_wait_ff - 4'd1;
      end else begin
         key_wait_in = key_wait_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_wait_ff <= 4'(NumRounds + 1);
      end else begin
         key_wait_ff <= key_wait_in;
      end
   end

   // one expansion step per register, so the key schedule is itself a pipeline
   always_comb begin
      rk_in[0] = {key_high_ff, key_low_ff};
      for (int i = 1; i <= NumRounds; i++) begin
         rk_in[i] = next_round_key(rk_ff[i-1], RCON[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= NumRounds; i++) begin
         rk_ff[i] <= rk_in[i];
      end
   end

   // encrypt stage r uses rk[r]; decrypt stage r uses rk[10-r]
   always_comb begin
      block_type x;
      st_in[0] = {req.block_high, req.block_low}
                 ^ ((req.op == OP_DECRYPT) ? rk_ff[NumRounds] : rk_ff[0]);
      for (int r = 1; r <= NumRounds; r++) begin
         x = sub_shift(st_ff[r-1], op_ff[r-1]);
         if (op_ff[r-1] == OP_DECRYPT) begin
            x = x ^ rk_ff[NumRounds-r];
            if (r < NumRounds) x = mix_inv(x);
         end else begin
            if (r < NumRounds) x = mix_fwd(x);
            x = x ^ rk_ff[r];
         end
         st_in[r] = x;
      end
      st_in[NumStages-1] = st_ff[NumStages-2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStages; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req.valid && key_ready;
         for (int i = 1; i < NumStages; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0] <= req.op;
         for (int i = 1; i < NumStages; i++) op_ff[i] <= op_ff[i-1];
         for (int i = 0; i < NumStages; i++) st_ff[i] <= st_in[i];
      end
   end

   assign rsp.valid       = vld_ff[NumStages-1];
   assign rsp.result_high = st_ff[NumStages-1][BlockW-1:HalfW];
   assign rsp.result_low  = st_ff[NumStages-1][HalfW-1:0];
   // unused request-side fields on the response channel
   assign rsp.op          = OP_ENCRYPT;
   assign rsp.block_high  = '0;
   assign rsp.block_low   = '0;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_high)
                                  && $stable(rsp.result_low))
      else $error("response word changed while stalled");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff[0]) && $stable(st_ff[0]))
      else $error("pipe moved during stall");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted word lost at entry");
`endif
endmodule

[bench/tb_aes128_block_cipher_core.sv]
`default_nettype none

module tb_aes128_block_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;
   import aes_pkg::*;

   localparam int CycleLimit = 600000;
   localparam int DrainWait  = 24;   // a little over the time a word takes through the pipeline
   localparam int KeySettle  = 16;   // longer than the key expansion takes to settle after a write
   localparam int LongHold   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_KEY_HIGH;
   logic [HalfW-1:0] csr_wdata = '0;

   aes_word_if req ();
   aes_word_if rsp ();

   aes128_block_cipher_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // --- predictor: byte-wise FIPS cipher / inverse cipher ---
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [127:0] aes_transform(op_type op, logic [127:0] key,
                                                 logic [127:0] blk);
      logic [7:0] st [16];
      logic [7:0] tmp [16];
      logic [7:0] rk [176];
      logic [7:0] w [4];
      logic [7:0] col [4];
      logic [7:0] coef [4];
      logic [7:0] rc [10];
      logic [7:0] u;
      logic [127:0] res;
      int dir, rnd, step;
      rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      for (int i = 0; i < 16; i++) begin
         rk[i] = key[127-8*i -: 8];
         st[i] = blk[127-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if ((i & 3) == 0) begin
            u    = w[0];
            w[0] = SBOX[w[1]] ^ rc[i/4-1];
            w[1] = SBOX[w[2]];
            w[2] = SBOX[w[3]];
            w[3] = SBOX[u];
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      if (op == OP_ENCRYPT) begin
         dir = 1; coef = '{8'h02, 8'h03, 8'h01, 8'h01};
      end else begin
         dir = 3; coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      end
      rnd = (op == OP_ENCRYPT) ? 0 : 10;
      for (int i = 0; i < 16; i++) st[i] ^= rk[16*rnd+i];
      for (step = 1; step <= 10; step++) begin
         rnd = (op == OP_ENCRYPT) ? step : 10 - step;
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
               u = st[((c + r*dir) & 3)*4 + r];
               tmp[c*4+r] = (op == OP_ENCRYPT) ? SBOX[u] : INV_SBOX[u];
            end
         // forward mixes before the key add, inverse after it
         if (op == OP_DECRYPT)
            for (int i = 0; i < 16; i++) tmp[i] ^= rk[16*rnd+i];
         if (step < 10)
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) begin
                  col[r] = 8'h00;
                  for (int k = 0; k < 4; k++)
                     col[r] ^= gf_mul(tmp[c*4+k], coef[(k-r) & 3]);
               end
               for (int r = 0; r < 4; r++) tmp[c*4+r] = col[r];
            end
         if (op == OP_ENCRYPT)
            for (int i = 0; i < 16; i++) tmp[i] ^= rk[16*rnd+i];
         st = tmp;
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   // --- shared state ---
   logic [127:0] cipher_key = '0;      // mirror of the key registers
   logic [127:0] pending_blocks [$];   // expected response words, oldest first
   logic [127:0] last_result = '0;
   logic         fixed_valid = 1'b0;   // typed-in answer for the word on offer
   logic [127:0] fixed_block = '0;
   int           fail_count = 0;
   int           cycle_count = 0;
   bit           calm = 1'b0;          // no idling on either side
   bit           hold_rsp = 1'b0;      // ask the receiver for a long hold-off

   // request side acceptance: record what must come back
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         pending_blocks.insert(pending_blocks.size(), fixed_valid ? fixed_block :
            aes_transform(req.op, cipher_key, {req.block_high, req.block_low}));
   end

   // response side: compare each taken word with the oldest expectation
   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_blocks.size() == 0) begin
            $error("unexpected response word %h_%h", rsp.result_high, rsp.result_low);
            fail_count++;
         end else begin
            want = pending_blocks.pop_front();
            last_result = {rsp.result_high, rsp.result_low};
            if (rsp.result_high !== want[127:64]) begin
               $error("result_high: expected %h, got %h", want[127:64], rsp.result_high);
               fail_count++;
            end
            if (rsp.result_low !== want[63:0]) begin
               $error("result_low: expected %h, got %h", want[63:0], rsp.result_low);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int n;
      rsp.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (LongHold) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            n = calm ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
               rsp.ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // key registers are only touched with the pipe empty
   task automatic load_key(logic [127:0] key);
      wait_drained();
      repeat (DrainWait) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= key[127:64];
      @(posedge clock);
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= key[63:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      cipher_key = key;
      repeat (KeySettle) @(posedge clock);
   endtask

   // offer one word; returns after the edge that takes it, valid still high
   task automatic send_word(op_type op, logic [127:0] blk, int gap,
                            bit known, logic [127:0] want);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.op         <= op;
      req.block_high <= blk[127:64];
      req.block_low  <= blk[63:0];
      fixed_valid    <= known;
      fixed_block    <= want;
      do @(posedge clock); while (!req.ready);
   endtask

   typedef struct {
      logic [127:0] key;
      op_type       op;
      logic [127:0] blk;
      bit           known;
      logic [127:0] want;
   } vector_row_type;

   localparam logic [127:0] Ones   = {128{1'b1}};
   localparam logic [127:0] FipsKey = 128'h000102030405060708090a0b0c0d0e0f;
   localparam logic [127:0] FipsPt  = 128'h00112233445566778899aabbccddeeff;
   localparam logic [127:0] FipsCt  = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
   localparam logic [127:0] ZeroCt  = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;

   initial begin
      vector_row_type rows [$];
      logic [127:0] key, blk;
      op_type op;
      int gap, phase_len;
      req.valid = 1'b0;
      req.op = OP_ENCRYPT;
      req.block_high = '0;
      req.block_low = '0;
      req.result_high = '0;
      req.result_low = '0;

      // all-zero key straight out of reset, then the extremes and FIPS vectors
      rows.insert(rows.size(), '{'0,      OP_ENCRYPT, '0,     1, ZeroCt});
      rows.insert(rows.size(), '{'0,      OP_DECRYPT, ZeroCt, 1, '0});
      rows.insert(rows.size(), '{'0,      OP_ENCRYPT, Ones,   0, '0});
      rows.insert(rows.size(), '{'0,      OP_DECRYPT, Ones,   0, '0});
      rows.insert(rows.size(), '{'0,      OP_DECRYPT, '0,     0, '0});
      rows.insert(rows.size(), '{FipsKey, OP_ENCRYPT, FipsPt, 1, FipsCt});
      rows.insert(rows.size(), '{FipsKey, OP_DECRYPT, FipsCt, 1, FipsPt});
      rows.insert(rows.size(), '{FipsKey, OP_ENCRYPT, '0,     0, '0});
      rows.insert(rows.size(), '{FipsKey, OP_ENCRYPT, Ones,   0, '0});
      rows.insert(rows.size(), '{Ones,    OP_ENCRYPT, '0,     0, '0});
      rows.insert(rows.size(), '{Ones,    OP_ENCRYPT, Ones,   0, '0});
      rows.insert(rows.size(), '{Ones,    OP_DECRYPT, '0,     0, '0});
      rows.insert(rows.size(), '{Ones,    OP_DECRYPT, Ones,   0, '0});
      rows.insert(rows.size(), '{Ones,    OP_ENCRYPT, FipsPt, 0, '0});
      rows.insert(rows.size(),
                  '{128'hffffffffffffffff0000000000000000, OP_ENCRYPT, FipsPt, 0, '0});
      rows.insert(rows.size(),
                  '{128'h0000000000000000ffffffffffffffff, OP_DECRYPT, FipsPt, 0, '0});

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].key !== cipher_key) begin
            req.valid <= 1'b0;
            load_key(rows[i].key);
         end
         send_word(rows[i].op, rows[i].blk, $urandom_range(0, 3),
                   rows[i].known, rows[i].want);
      end

      // random phases, each under its own key; some keys at the extremes
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       key = Ones;
            3:       key = '0;
            default: key = {$urandom, $urandom, $urandom, $urandom};
         endcase
         req.valid <= 1'b0;
         load_key(key);
         calm = (phase == 2);
         phase_len = 205;
         for (int n = 0; n < phase_len; n++) begin
            // stall the output for a while with the input kept busy
            if (phase == 4 && n == 20) hold_rsp = 1'b1;
            // stop and let every word come back before carrying on
            if (phase == 5 && n == 100) begin
               req.valid <= 1'b0;
               wait_drained();
               @(posedge clock);
            end
            gap = (calm || hold_rsp) ? 0 : $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) begin
               // round trip: send back a recent response in either direction
               op  = $urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT;
               blk = last_result;
            end else begin
               op  = op_type'($urandom_range(0, 1));
               blk = {$urandom, $urandom, $urandom, $urandom};
            end
            send_word(op, blk, gap, 1'b0, '0);
         end
      end
      req.valid <= 1'b0;

      wait_drained();
      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0 && pending_blocks.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/aes_pkg.sv
rtl/core/aes_word_if.sv
rtl/core/aes128_block_cipher_core.sv
bench/tb_aes128_block_cipher_core.sv
